FILE: rtl/bitmap_run_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap run allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BRA_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define BRA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BRA_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define BRA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared types, constants and the per-byte run scan.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned MaxBytesDef = 512;
  localparam int unsigned CfgW        = 10;
  localparam int unsigned ActW        = 2;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned LenW        = 13;
  localparam int unsigned MemAddrW    = 16;
  localparam int unsigned WideW       = 17;
  localparam logic [CfgW-1:0] CfgReset = 10'd512;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_TEST  = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_WRITE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                we;
    logic [MemAddrW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [MemAddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic            bit_state;
    logic            found;
    logic [IdxW-1:0] run_start;
  } result_t;

  typedef struct packed {
    logic            hit;
    logic [2:0]      pos;
    logic [LenW-1:0] count;
  } scan_t;

  function automatic scan_t scan_byte(input logic [7:0] data, input logic [LenW-1:0] count,
                                      input logic [LenW-1:0] len);
    scan_t           r;
    logic [LenW-1:0] c;
    logic [3:0]      z;
    logic            clean;
    logic            h;
    logic [2:0]      p;
    c     = count;
    z     = 4'd0;
    clean = 1'b1;
    h     = 1'b0;
    p     = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (data[k]) begin
        z     = 4'd0;
        clean = 1'b0;
      end else begin
        z = z + 4'd1;
      end
      c = clean ? (count + LenW'(k + 1)) : {{(LenW-4){1'b0}}, z};
      if (!h && (c == len)) begin
        h = 1'b1;
        p = 3'(k);
      end
    end
    r.hit   = h;
    r.pos   = p;
    r.count = c;
    return r;
  endfunction

endpackage

FILE: rtl/bra_mem.sv
// ----------------------------------------------------------------------------
// Bitmap byte store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bra_mem #(
  parameter int unsigned Depth = bra_pkg::MaxBytesDef,
  parameter int unsigned AddrW = 9
) (
  input  logic              clk_i,
  input  bra_pkg::mem_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AddrW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AddrW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bra_seq.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator sequencer
// Clear sweeps, read-modify-write of single bits and the byte-serial run search.
// ----------------------------------------------------------------------------
`include "bitmap_run_allocator_macros.svh"

module bra_seq #(
  parameter int unsigned MaxBytes = bra_pkg::MaxBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bra_pkg::CfgW-1:0]     bytes_in_use_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bra_pkg::ActW-1:0]     action_i,
  input  logic [bra_pkg::IdxW-1:0]     bit_index_i,
  input  logic [bra_pkg::LenW-1:0]     run_length_i,
  input  logic                         bit_value_i,
  output bra_pkg::mem_req_t            mem_req_o,
  input  logic [7:0]                   mem_rdata_i,
  output logic                         done_valid_o,
  input  logic                         out_ready_i,
  output bra_pkg::result_t             result_o
);

  localparam int unsigned CovW = bra_pkg::CfgW;

  bra_pkg::state_e              state_q, state_d;
  bra_pkg::action_e             act_q;
  logic [bra_pkg::IdxW-1:0]     idx_q;
  logic [bra_pkg::LenW-1:0]     len_q;
  logic                         val_q;
  logic [CovW-1:0]              cov_q;
  logic [CovW-1:0]              cnt_q;
  logic [bra_pkg::WideW-1:0]    init_q;
  logic                         dv_q;
  logic [CovW-1:0]              db_q;
  logic [bra_pkg::LenW-1:0]     run_q;
  bra_pkg::result_t             res_q;

  bra_pkg::action_e             act_in;
  logic [CovW-1:0]              cov_in;
  logic                         in_range;
  logic                         search_ok;
  logic                         init_last;
  logic                         rd_more;
  logic [7:0]                   bit_mask;
  bra_pkg::scan_t               scan;
  logic [bra_pkg::LenW-1:0]     start;

  assign act_in    = bra_pkg::action_e'(action_i);
  assign cov_in    = ({7'd0, bytes_in_use_i} > bra_pkg::WideW'(MaxBytes))
                   ? CovW'(MaxBytes) : bytes_in_use_i;
  assign in_range  = {8'd0, bit_index_i[11:3]} < bra_pkg::WideW'(MaxBytes);
  assign search_ok = (run_length_i != '0) && (run_length_i <= {cov_in, 3'b000});
  assign init_last = init_q == bra_pkg::WideW'(MaxBytes - 1);
  assign rd_more   = cnt_q < cov_q;
  assign bit_mask  = 8'd1 << idx_q[2:0];
  assign scan      = bra_pkg::scan_byte(mem_rdata_i, run_q, len_q);
  assign start     = {db_q, scan.pos} + 13'd1 - len_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bra_pkg::ST_INIT: begin
        if (init_last) state_d = bra_pkg::ST_IDLE;
      end
      bra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (act_in)
            bra_pkg::ACT_CLEAR: state_d = (cov_in == '0) ? bra_pkg::ST_DONE : bra_pkg::ST_CLEAR;
            bra_pkg::ACT_FIND:  state_d = search_ok ? bra_pkg::ST_SEARCH : bra_pkg::ST_DONE;
            default:            state_d = in_range ? bra_pkg::ST_RMW_RD : bra_pkg::ST_DONE;
          endcase
        end
      end
      bra_pkg::ST_CLEAR: begin
        if (cnt_q == cov_q - 10'd1) state_d = bra_pkg::ST_DONE;
      end
      bra_pkg::ST_RMW_RD: state_d = bra_pkg::ST_RMW_WR;
      bra_pkg::ST_RMW_WR: state_d = bra_pkg::ST_DONE;
      bra_pkg::ST_SEARCH: begin
        if (dv_q && (scan.hit || db_q == cov_q - 10'd1)) state_d = bra_pkg::ST_DONE;
      end
      bra_pkg::ST_DONE: begin
        if (out_ready_i) state_d = bra_pkg::ST_IDLE;
      end
      default: state_d = bra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req_o    = '0;
    in_ready_o   = 1'b0;
    done_valid_o = 1'b0;
    case (state_q)
      bra_pkg::ST_INIT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = init_q[bra_pkg::MemAddrW-1:0];
      end
      bra_pkg::ST_IDLE: in_ready_o = 1'b1;
      bra_pkg::ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {6'd0, cnt_q};
      end
      bra_pkg::ST_RMW_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = {7'd0, idx_q[11:3]};
      end
      bra_pkg::ST_RMW_WR: begin
        mem_req_o.we    = act_q == bra_pkg::ACT_WRITE;
        mem_req_o.waddr = {7'd0, idx_q[11:3]};
        mem_req_o.wdata = val_q ? (mem_rdata_i | bit_mask) : (mem_rdata_i & ~bit_mask);
      end
      bra_pkg::ST_SEARCH: begin
        mem_req_o.re    = rd_more;
        mem_req_o.raddr = {6'd0, cnt_q};
      end
      bra_pkg::ST_DONE: done_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bra_pkg::ST_INIT;
      init_q  <= '0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bra_pkg::ST_INIT) init_q <= init_q + 17'd1;
      if (state_q == bra_pkg::ST_SEARCH) begin
        dv_q <= rd_more;
      end else begin
        dv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          act_q <= act_in;
          idx_q <= bit_index_i;
          len_q <= run_length_i;
          val_q <= bit_value_i;
          cov_q <= cov_in;
          cnt_q <= '0;
          run_q <= '0;
          res_q <= '0;
        end
      end
      bra_pkg::ST_CLEAR: cnt_q <= cnt_q + 10'd1;
      bra_pkg::ST_RMW_WR: begin
        if (act_q == bra_pkg::ACT_TEST) res_q.bit_state <= mem_rdata_i[idx_q[2:0]];
      end
      bra_pkg::ST_SEARCH: begin
        if (rd_more) cnt_q <= cnt_q + 10'd1;
        db_q <= cnt_q;
        if (dv_q) begin
          run_q <= scan.count;
          if (scan.hit) begin
            res_q.found     <= 1'b1;
            res_q.run_start <= start[bra_pkg::IdxW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o = res_q;

  `BRA_ASSERT_IMPL(a_no_write_in_search, clk_i, rst_ni, state_q == bra_pkg::ST_SEARCH, !mem_req_o.we, "write during search")
  `BRA_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != bra_pkg::ST_IDLE, "accepted request left sequencer idle")
  `BRA_ASSERT_IMPL(a_found_only_search, clk_i, rst_ni, done_valid_o && res_q.found, act_q == bra_pkg::ACT_FIND, "found flag outside search")
  `BRA_ASSERT_IMPL(a_scan_in_cover, clk_i, rst_ni, dv_q, db_q < cov_q, "scanned byte beyond coverage")

endmodule

FILE: rtl/bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator
// Allocation bitmap with clear, bit test, bit write and lowest free-run search.
//
//   channel   dir   signals                       contents
//   s_axis    in    tvalid tready tdata tuser     one request
//   m_axis    out   tvalid tready tdata           one result per request
//   cfg       in    cfg_we_i cfg_wdata_i          bytes_in_use
//
// After reset a clearing pass writes all MaxBytes bytes, one per cycle; no request
// is taken until it ends. Test reads the addressed byte; write reads it, modifies
// the bit and writes it back. Clear writes one covered byte per cycle. Search scans
// one byte per cycle through the memory read port. A result waits in the output
// register while the next request runs.
// ----------------------------------------------------------------------------
module bitmap_run_allocator #(
  parameter int unsigned MaxBytes = bra_pkg::MaxBytesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bra_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,  // bit_index[11:0], run_length[24:12], bit_value[25]
  input  logic [1:0]               s_axis_tuser,  // action[1:0]
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [15:0]              m_axis_tdata   // bit_state[0], found[1], run_start[13:2]
);

  localparam int unsigned AddrW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

  logic [bra_pkg::CfgW-1:0] bytes_in_use_q;
  bra_pkg::mem_req_t        mem_req;
  logic [7:0]               mem_rdata;
  logic                     done_valid;
  logic                     out_free;
  bra_pkg::result_t         result;
  logic                     out_valid_q;
  bra_pkg::result_t         out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_in_use_q <= bra_pkg::CfgReset;
    end else if (cfg_we_i) begin
      bytes_in_use_q <= cfg_wdata_i;
    end
  end

  bra_mem #(
    .Depth (MaxBytes),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bra_seq #(
    .MaxBytes (MaxBytes)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bytes_in_use_i (bytes_in_use_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .action_i       (s_axis_tuser),
    .bit_index_i    (s_axis_tdata[11:0]),
    .run_length_i   (s_axis_tdata[24:12]),
    .bit_value_i    (s_axis_tdata[25]),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .done_valid_o   (done_valid),
    .out_ready_i    (out_free),
    .result_o       (result)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= done_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done_valid) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.run_start, out_res_q.found, out_res_q.bit_state};

endmodule
